// ===== src/pso_pkg.sv =====
// ----------------------------------------------------------------------------
// pso_pkg
// Shared constants, types and helpers for the particle swarm update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pso_pkg;

  // Storage geometry
  localparam int MAX_PARTICLES = 64;
  localparam int MAX_DIMS      = 8;
  localparam int PART_W        = $clog2(MAX_PARTICLES);
  localparam int DIM_W         = $clog2(MAX_DIMS);
  localparam int ADDR_W        = PART_W + DIM_W;
  localparam int MEM_DEPTH     = MAX_PARTICLES * MAX_DIMS;
  localparam int CNT_W         = $clog2(MAX_DIMS + 1);

  // Field widths
  localparam int OP_W       = 2;
  localparam int PARTICLE_W = 6;
  localparam int DIMF_W     = 3;
  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int PCOUNT_W   = 7;
  localparam int DCOUNT_W   = 4;

  // Update arithmetic: diff is exact in 33 bits, product by an unsigned Q0.16
  // fraction, the factor two folds into a shift of FRAC_W - 1.
  localparam int DIFF_W     = WORD_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_W + 1;
  localparam int PULL_SHIFT = FRAC_W - 1;
  localparam int PULL_W     = PROD_W - PULL_SHIFT;
  localparam int SUM_W      = PULL_W + 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_FITNESS = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 1'b1;

  localparam logic [PCOUNT_W-1:0] PARTS_RESET = 7'd64;
  localparam logic [DCOUNT_W-1:0] DIMS_RESET  = 4'd2;
  localparam logic [WORD_W-1:0]   FIT_MAX     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0]   WORD_MIN    = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_PLAIN,
    S_MV_RD,
    S_MV_MUL,
    S_MV_SUM,
    S_MV_WR,
    S_FIT_RD,
    S_FIT_UPD,
    S_COPY,
    S_OUT_RD,
    S_OUT_RES
  } state_t;

  typedef struct packed {
    logic             latch;
    logic             load_wr;
    logic             mv_rd;
    logic             mv_mul;
    logic             mv_sum;
    logic             mv_wr;
    logic             fit_rd;
    logic             fit_upd;
    logic             copy_rd;
    logic             copy_wr;
    logic [CNT_W-1:0] copy_idx;
    logic [CNT_W-1:0] wr_idx;
    logic             out_rd;
    logic             res_load;
    logic             res_move;
    logic             res_fit;
    logic             res_plain;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             idx_err;
    logic             improve;
    logic [CNT_W-1:0] dims;
  } status_t;

  // Clamp a wide signed sum to a 32-bit word
  function automatic logic [WORD_W-1:0] sat_word(input logic [SUM_W-1:0] v);
    logic [WORD_W-1:0] r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:WORD_W-1])) begin
      r = FIT_MAX;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:WORD_W-1])) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/particle_swarm_update_engine.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update_engine
// Particle swarm update engine: per-particle stores, best tracking and the
// fixed-point velocity and position update.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low; its result
// appears for a single cycle with done high and must be captured then, as
// nothing holds it. A load, an index error or an unused op code goes from
// dispatch to its result state, a move steps through read, multiply, sum and
// write, and a fitness report reads and updates the best fitness and, when
// it improves, copies the position words up to the dimension count (capped
// at eight): the copy moves one word per cycle through the single read port
// of the position store. busy drops as done rises, so the next command may be
// issued during the result cycle. There is no clearing pass after reset; the
// user must write configuration only while busy is low; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_swarm_update_engine
  import pso_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  output logic                              done,
  input  wire logic        [OP_W-1:0]       op,
  input  wire logic        [PARTICLE_W-1:0] particle,
  input  wire logic        [DIMF_W-1:0]     dim,
  input  wire logic signed [WORD_W-1:0]     start_position,
  input  wire logic signed [WORD_W-1:0]     start_velocity,
  input  wire logic signed [WORD_W-1:0]     fitness,
  input  wire logic        [FRAC_W-1:0]     rand_cognitive,
  input  wire logic        [FRAC_W-1:0]     rand_social,
  output logic signed      [WORD_W-1:0]     new_position,
  output logic signed      [WORD_W-1:0]     new_velocity,
  output logic                              personal_improved,
  output logic                              global_improved,
  output logic signed      [WORD_W-1:0]     global_best_fitness,
  output logic                              index_error,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  pso_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  pso_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .op                  (op),
    .particle            (particle),
    .dim                 (dim),
    .start_position      (start_position),
    .start_velocity      (start_velocity),
    .fitness             (fitness),
    .rand_cognitive      (rand_cognitive),
    .rand_social         (rand_social),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .done                (done),
    .new_position        (new_position),
    .new_velocity        (new_velocity),
    .personal_improved   (personal_improved),
    .global_improved     (global_improved),
    .global_best_fitness (global_best_fitness),
    .index_error         (index_error)
  );

endmodule

`default_nettype wire

// ===== src/pso_ctrl.sv =====
// ----------------------------------------------------------------------------
// pso_ctrl
// Sequencer for load, move, fitness and rejected operations; drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_ctrl
  import pso_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.idx_err) begin
          state_next = S_PLAIN;
        end else begin
          case (status.op)
            OP_LOAD:    state_next = S_LOAD;
            OP_FITNESS: state_next = S_FIT_RD;
            OP_MOVE:    state_next = S_MV_RD;
            default:    state_next = S_PLAIN;
          endcase
        end
      end
      S_LOAD:    state_next = S_IDLE;
      S_PLAIN:   state_next = S_IDLE;
      S_MV_RD:   state_next = S_MV_MUL;
      S_MV_MUL:  state_next = S_MV_SUM;
      S_MV_SUM:  state_next = S_MV_WR;
      S_MV_WR:   state_next = S_IDLE;
      S_FIT_RD:  state_next = S_FIT_UPD;
      S_FIT_UPD: begin
        cnt_next   = '0;
        state_next = status.improve ? S_COPY : S_OUT_RD;
      end
      S_COPY: begin
        // read word cnt while writing back word cnt-1
        if (cnt == status.dims) begin
          state_next = S_OUT_RD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT_RD:  state_next = S_OUT_RES;
      S_OUT_RES: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_DISPATCH: ;
      S_LOAD: begin
        cmd.load_wr  = 1'b1;
        cmd.res_load = 1'b1;
      end
      S_PLAIN:   cmd.res_plain = 1'b1;
      S_MV_RD:   cmd.mv_rd     = 1'b1;
      S_MV_MUL:  cmd.mv_mul    = 1'b1;
      S_MV_SUM:  cmd.mv_sum    = 1'b1;
      S_MV_WR: begin
        cmd.mv_wr    = 1'b1;
        cmd.res_move = 1'b1;
      end
      S_FIT_RD:  cmd.fit_rd  = 1'b1;
      S_FIT_UPD: cmd.fit_upd = 1'b1;
      S_COPY: begin
        cmd.copy_rd  = (cnt < status.dims);
        cmd.copy_idx = cnt;
        cmd.copy_wr  = (cnt != '0);
        cmd.wr_idx   = cnt - 1'b1;
      end
      S_OUT_RD:  cmd.out_rd  = 1'b1;
      S_OUT_RES: cmd.res_fit = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pso_dp.sv =====
// ----------------------------------------------------------------------------
// pso_dp
// Particle stores, best tracking, velocity update arithmetic and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_dp
  import pso_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  output status_t                           status,
  input  wire logic        [OP_W-1:0]       op,
  input  wire logic        [PARTICLE_W-1:0] particle,
  input  wire logic        [DIMF_W-1:0]     dim,
  input  wire logic signed [WORD_W-1:0]     start_position,
  input  wire logic signed [WORD_W-1:0]     start_velocity,
  input  wire logic signed [WORD_W-1:0]     fitness,
  input  wire logic        [FRAC_W-1:0]     rand_cognitive,
  input  wire logic        [FRAC_W-1:0]     rand_social,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data,
  output logic                              done,
  output logic signed      [WORD_W-1:0]     new_position,
  output logic signed      [WORD_W-1:0]     new_velocity,
  output logic                              personal_improved,
  output logic                              global_improved,
  output logic signed      [WORD_W-1:0]     global_best_fitness,
  output logic                              index_error
);

  // Latched command fields
  logic [OP_W-1:0]       op_q;
  logic [PARTICLE_W-1:0] p_q;
  logic [DIMF_W-1:0]     d_q;
  logic [WORD_W-1:0]     sp_q, sv_q, fit_q;
  logic [FRAC_W-1:0]     r1_q, r2_q;

  logic [PCOUNT_W-1:0]   parts_q;
  logic [DCOUNT_W-1:0]   dims_q;

  logic [WORD_W-1:0] pos_mem [MEM_DEPTH];
  logic [WORD_W-1:0] vel_mem [MEM_DEPTH];
  logic [WORD_W-1:0] pbp_mem [MEM_DEPTH];
  logic [WORD_W-1:0] pbf_mem [MAX_PARTICLES];
  logic              pbf_vld [MAX_PARTICLES];
  logic [WORD_W-1:0] gbest   [MAX_DIMS];
  logic [WORD_W-1:0] gbf;

  logic [WORD_W-1:0] pos_rd, vel_rd, pb_rd, pbf_rd;
  logic              pbf_vld_rd;

  logic [ADDR_W-1:0] k_addr, pos_raddr, pbp_waddr;
  logic [PART_W-1:0] p_idx;
  logic              p_ok, d_ok;

  logic signed [DIFF_W-1:0] cog_diff, soc_diff;
  logic signed [PROD_W-1:0] cog_prod, soc_prod;
  logic        [SUM_W-1:0]  vel_sum, pos_sum;
  logic        [WORD_W-1:0] v_q, moved_pos, pbf_cur, gb_word;
  logic                     pimp, gimp, pimp_q, gimp_q;
  logic                     pos_we, pbp_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= op;
      p_q   <= particle;
      d_q   <= dim;
      sp_q  <= start_position;
      sv_q  <= start_velocity;
      fit_q <= fitness;
      r1_q  <= rand_cognitive;
      r2_q  <= rand_social;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parts_q <= PARTS_RESET;
      dims_q  <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PARTICLES: parts_q <= cfg_data[PCOUNT_W-1:0];
        CFG_DIMS:      dims_q  <= cfg_data[DCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Range checks against the configured counts, capped at the storage size
  assign p_ok = (32'(p_q) < 32'(parts_q)) && (32'(p_q) < MAX_PARTICLES);
  assign d_ok = (32'(d_q) < 32'(dims_q)) && (32'(d_q) < MAX_DIMS);

  always_comb begin
    status.op = op_q;
    case (op_q)
      OP_LOAD, OP_MOVE: status.idx_err = !(p_ok && d_ok);
      OP_FITNESS:       status.idx_err = !p_ok;
      default:          status.idx_err = 1'b0;
    endcase
    status.improve = pimp || gimp;
    status.dims    = (32'(dims_q) > MAX_DIMS) ? CNT_W'(MAX_DIMS) : CNT_W'(dims_q);
  end

  assign p_idx     = p_q[PART_W-1:0];
  assign k_addr    = {p_idx, d_q[DIM_W-1:0]};
  assign pos_raddr = cmd.copy_rd ? {p_idx, cmd.copy_idx[DIM_W-1:0]} : k_addr;
  assign pbp_waddr = {p_idx, cmd.wr_idx[DIM_W-1:0]};

  // Position and velocity stores
  assign pos_we = cmd.load_wr || cmd.mv_wr;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[k_addr] <= cmd.load_wr ? sp_q : moved_pos;
    if (cmd.mv_rd || cmd.out_rd || cmd.copy_rd) pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) vel_mem[k_addr] <= cmd.load_wr ? sv_q : v_q;
    if (cmd.mv_rd || cmd.out_rd) vel_rd <= vel_mem[k_addr];
  end

  // Personal-best positions
  assign pbp_we = cmd.copy_wr && pimp_q;

  always_ff @(posedge clk) begin
    if (pbp_we) pbp_mem[pbp_waddr] <= pos_rd;
    if (cmd.mv_rd) pb_rd <= pbp_mem[k_addr];
  end

  // Personal-best fitness: an entry never written reads as the largest value
  assign pbf_cur = pbf_vld_rd ? pbf_rd : FIT_MAX;
  assign pimp    = $signed(fit_q) < $signed(pbf_cur);
  assign gimp    = $signed(fit_q) < $signed(gbf);

  always_ff @(posedge clk) begin
    if (cmd.fit_upd && pimp) pbf_mem[p_idx] <= fit_q;
    if (cmd.fit_rd) begin
      pbf_rd     <= pbf_mem[p_idx];
      pbf_vld_rd <= pbf_vld[p_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PARTICLES; i++) pbf_vld[i] <= 1'b0;
    end else if (cmd.fit_upd && pimp) begin
      pbf_vld[p_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fit_upd) begin
      pimp_q <= pimp;
      gimp_q <= gimp;
    end
  end

  // Global best
  always_ff @(posedge clk) begin
    if (rst) begin
      gbf <= FIT_MAX;
      for (int i = 0; i < MAX_DIMS; i++) gbest[i] <= '0;
    end else begin
      if (cmd.fit_upd && gimp) gbf <= fit_q;
      if (cmd.copy_wr && gimp_q) gbest[cmd.wr_idx[DIM_W-1:0]] <= pos_rd;
    end
  end

  assign gb_word = gbest[d_q[DIM_W-1:0]];

  // Velocity update: two pulls, each floor(diff * r / 2^15)
  assign cog_diff = $signed({pb_rd[WORD_W-1], pb_rd}) - $signed({pos_rd[WORD_W-1], pos_rd});
  assign soc_diff = $signed({gb_word[WORD_W-1], gb_word})
                  - $signed({pos_rd[WORD_W-1], pos_rd});

  always_ff @(posedge clk) begin
    if (cmd.mv_mul) begin
      cog_prod <= cog_diff * $signed({1'b0, r1_q});
      soc_prod <= soc_diff * $signed({1'b0, r2_q});
    end
  end

  assign vel_sum = {{(SUM_W-WORD_W){vel_rd[WORD_W-1]}}, vel_rd}
                 + {{(SUM_W-PULL_W){cog_prod[PROD_W-1]}}, cog_prod[PROD_W-1:PULL_SHIFT]}
                 + {{(SUM_W-PULL_W){soc_prod[PROD_W-1]}}, soc_prod[PROD_W-1:PULL_SHIFT]};

  always_ff @(posedge clk) begin
    if (cmd.mv_sum) v_q <= sat_word(vel_sum);
  end

  assign pos_sum   = {{(SUM_W-WORD_W){pos_rd[WORD_W-1]}}, pos_rd}
                   + {{(SUM_W-WORD_W){v_q[WORD_W-1]}}, v_q};
  assign moved_pos = sat_word(pos_sum);

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load || cmd.res_move || cmd.res_fit || cmd.res_plain;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      new_position      <= sp_q;
      new_velocity      <= sv_q;
      personal_improved <= 1'b0;
      global_improved   <= 1'b0;
      index_error       <= 1'b0;
    end else if (cmd.res_move) begin
      new_position      <= moved_pos;
      new_velocity      <= v_q;
      personal_improved <= 1'b0;
      global_improved   <= 1'b0;
      index_error       <= 1'b0;
    end else if (cmd.res_fit) begin
      new_position      <= d_ok ? pos_rd : '0;
      new_velocity      <= d_ok ? vel_rd : '0;
      personal_improved <= pimp_q;
      global_improved   <= gimp_q;
      index_error       <= 1'b0;
    end else if (cmd.res_plain) begin
      new_position      <= '0;
      new_velocity      <= '0;
      personal_improved <= 1'b0;
      global_improved   <= 1'b0;
      index_error       <= status.idx_err;
    end
  end

  assign global_best_fitness = gbf;

endmodule

`default_nettype wire

// ===== src/pso_checker.sv =====
// ----------------------------------------------------------------------------
// pso_checker
// Port-level checks on the command and result timing of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_checker
  import pso_pkg::*;
(
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done,
  input wire logic signed [WORD_W-1:0]     new_position,
  input wire logic signed [WORD_W-1:0]     new_velocity,
  input wire logic                         personal_improved,
  input wire logic                         global_improved,
  input wire logic signed [WORD_W-1:0]     global_best_fitness,
  input wire logic                         index_error
);

  // An accepted command keeps the engine busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("engine not busy after an accepted command");

  // A result beat only follows a busy cycle and ends it
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat outside the end of a command");

  // One beat per command: no two result cycles in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // A rejected index leaves every result field clear
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> !personal_improved && !global_improved &&
                            new_position == '0 && new_velocity == '0)
    else $error("index error with non-zero result fields");

  // The global best fitness only ever moves down between resets
  a_global_drop: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || global_best_fitness <= $past(global_best_fitness))
    else $error("global best fitness rose");

endmodule

bind particle_swarm_update_engine pso_checker u_pso_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the particle swarm update engine. Commands go in
// through the start/busy handshake with random gaps, and each result strobe
// is compared against an in-bench model of the swarm stores and best
// tracking. The run steps through several swarm sizes: full, single
// particle, empty, and values above the storage limits.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pso_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              STALL_LIMIT = 2000;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [PARTICLE_W-1:0] particle;
    logic [DIMF_W-1:0]     dim;
    logic [WORD_W-1:0]     start_position;
    logic [WORD_W-1:0]     start_velocity;
    logic [WORD_W-1:0]     fitness;
    logic [FRAC_W-1:0]     rand_cognitive;
    logic [FRAC_W-1:0]     rand_social;
  } swarm_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] new_position;
    logic [WORD_W-1:0] new_velocity;
    logic              personal_improved;
    logic              global_improved;
    logic [WORD_W-1:0] global_best_fitness;
    logic              index_error;
  } swarm_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    done;
  logic [OP_W-1:0]         op = '0;
  logic [PARTICLE_W-1:0]   particle = '0;
  logic [DIMF_W-1:0]       dim = '0;
  logic signed [WORD_W-1:0] start_position = '0;
  logic signed [WORD_W-1:0] start_velocity = '0;
  logic signed [WORD_W-1:0] fitness = '0;
  logic [FRAC_W-1:0]       rand_cognitive = '0;
  logic [FRAC_W-1:0]       rand_social = '0;
  logic signed [WORD_W-1:0] new_position;
  logic signed [WORD_W-1:0] new_velocity;
  logic                    personal_improved;
  logic                    global_improved;
  logic signed [WORD_W-1:0] global_best_fitness;
  logic                    index_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Swarm model: stores, best tracking, register copies
  logic signed [WORD_W-1:0] sw_pos       [MEM_DEPTH];
  logic signed [WORD_W-1:0] sw_vel       [MEM_DEPTH];
  logic signed [WORD_W-1:0] sw_pbest     [MEM_DEPTH];
  logic signed [WORD_W-1:0] sw_pbest_fit [MAX_PARTICLES];
  logic signed [WORD_W-1:0] sw_gbest     [MAX_DIMS];
  logic signed [WORD_W-1:0] sw_gbest_fit;
  bit                       pos_loaded   [MEM_DEPTH];
  bit                       pbest_valid  [MEM_DEPTH];
  logic [PCOUNT_W-1:0]      swarm_parts_reg;
  logic [DCOUNT_W-1:0]      swarm_dims_reg;

  swarm_result_t predicted_outcomes[$];
  swarm_result_t due;

  int mismatches = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  int n_items = 0;
  int n_moves = 0;
  int n_reports = 0;
  int n_pbest = 0;
  int n_gbest = 0;
  int n_errors = 0;
  int n_reg_writes = 0;

  particle_swarm_update_engine dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .done                (done),
    .op                  (op),
    .particle            (particle),
    .dim                 (dim),
    .start_position      (start_position),
    .start_velocity      (start_velocity),
    .fitness             (fitness),
    .rand_cognitive      (rand_cognitive),
    .rand_social         (rand_social),
    .new_position        (new_position),
    .new_velocity        (new_velocity),
    .personal_improved   (personal_improved),
    .global_improved     (global_improved),
    .global_best_fitness (global_best_fitness),
    .index_error         (index_error),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned live_particles();
    return (swarm_parts_reg > MAX_PARTICLES) ? MAX_PARTICLES : swarm_parts_reg;
  endfunction

  function automatic int unsigned live_dims();
    return (swarm_dims_reg > MAX_DIMS) ? MAX_DIMS : swarm_dims_reg;
  endfunction

  function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return FIT_MAX;
    if (v < -64'sd2147483648) return WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  // Advance the swarm model by one command and return the result it gives
  function automatic swarm_result_t apply_swarm_op(input swarm_cmd_t c);
    swarm_result_t r;
    int unsigned np, nd, base, k, j;
    bit p_ok, d_ok;
    longint x, cog, soc;
    logic signed [WORD_W-1:0] v, f;
    np = live_particles();
    nd = live_dims();
    p_ok = c.particle < np;
    d_ok = c.dim < nd;
    base = int'(c.particle) * MAX_DIMS;
    k = base + c.dim;
    r = '0;
    if (c.op == OP_LOAD || c.op == OP_MOVE) begin
      if (!p_ok || !d_ok) begin
        r.index_error = 1'b1;
      end else begin
        if (c.op == OP_LOAD) begin
          sw_pos[k] = c.start_position;
          sw_vel[k] = c.start_velocity;
          pos_loaded[k] = 1'b1;
        end else begin
          // pulls are floor(diff * r / 2^15), diff exact in 33 bits
          x = longint'(sw_pos[k]);
          cog = ((longint'(sw_pbest[k]) - x) * longint'(c.rand_cognitive)) >>> 15;
          soc = ((longint'(sw_gbest[c.dim]) - x) * longint'(c.rand_social)) >>> 15;
          v = clamp_word(longint'(sw_vel[k]) + cog + soc);
          sw_vel[k] = v;
          sw_pos[k] = clamp_word(x + longint'(v));
        end
        r.new_position = sw_pos[k];
        r.new_velocity = sw_vel[k];
      end
    end else if (c.op == OP_FITNESS) begin
      if (!p_ok) begin
        r.index_error = 1'b1;
      end else begin
        f = c.fitness;
        if (f < sw_pbest_fit[c.particle]) begin
          sw_pbest_fit[c.particle] = f;
          for (j = 0; j < nd; j++) begin
            sw_pbest[base + j] = sw_pos[base + j];
            pbest_valid[base + j] = 1'b1;
          end
          r.personal_improved = 1'b1;
        end
        if (f < sw_gbest_fit) begin
          sw_gbest_fit = f;
          for (j = 0; j < nd; j++) sw_gbest[j] = sw_pos[base + j];
          r.global_improved = 1'b1;
        end
        if (d_ok) begin
          r.new_position = sw_pos[k];
          r.new_velocity = sw_vel[k];
        end
      end
    end
    r.global_best_fitness = sw_gbest_fit;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] draw_fitness(input int unsigned p);
    longint fl;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7:
        fl = longint'(sw_pbest_fit[p]) - longint'($urandom_range(1, 5000));
      8, 9, 10:
        fl = longint'(sw_gbest_fit) - longint'($urandom_range(1, 5000));
      11, 12, 13, 14, 15, 16:
        fl = longint'(sw_pbest_fit[p]) + longint'($urandom_range(0, 5000));
      default:
        fl = longint'($signed($urandom()));
    endcase
    return clamp_word(fl);
  endfunction

  // Turn a command that would read an unwritten store entry into the load or
  // fitness report that gets the particle there
  function automatic swarm_cmd_t legalise(input swarm_cmd_t c);
    int unsigned np, nd, base, k, j;
    np = live_particles();
    nd = live_dims();
    base = int'(c.particle) * MAX_DIMS;
    k = base + c.dim;
    if (c.particle >= np) return c;
    if (c.op == OP_MOVE && c.dim < nd) begin
      if (!pos_loaded[k]) begin
        c.op = OP_LOAD;
      end else if (!pbest_valid[k]) begin
        if (sw_pbest_fit[c.particle] != WORD_MIN) begin
          c.op = OP_FITNESS;
          c.fitness = sw_pbest_fit[c.particle] - 1;
        end else begin
          c.op = OP_LOAD;
        end
      end
    end
    for (j = 0; j < nd; j++) begin
      if (c.op == OP_FITNESS && !pos_loaded[base + j]) begin
        c.op = OP_LOAD;
        c.dim = DIMF_W'(j);
      end
    end
    return c;
  endfunction

  function automatic swarm_cmd_t draw_swarm_cmd();
    swarm_cmd_t c;
    int unsigned np, nd, pick;
    np = live_particles();
    nd = live_dims();
    pick = $urandom_range(0, 99);
    c.particle = PARTICLE_W'($urandom());
    c.dim = DIMF_W'($urandom());
    if (np == 0 || nd == 0 || pick < 10) begin
      // noise: indexes past the configured counts, or the unused code
      case ($urandom_range(0, 3))
        0: c.op = OP_LOAD;
        1: c.op = OP_FITNESS;
        2: c.op = OP_MOVE;
        default: c.op = OP_UNUSED;
      endcase
      if (np < MAX_PARTICLES && $urandom_range(0, 1) == 1) begin
        c.particle = PARTICLE_W'($urandom_range(np, MAX_PARTICLES - 1));
      end else if (nd < MAX_DIMS) begin
        c.dim = DIMF_W'($urandom_range(nd, MAX_DIMS - 1));
      end
    end else begin
      // keep most traffic on a few particles so moves follow their reports
      c.particle = ($urandom_range(0, 3) != 0 && np > 8) ?
                   PARTICLE_W'($urandom_range(0, 7)) :
                   PARTICLE_W'($urandom_range(0, np - 1));
      c.dim = DIMF_W'($urandom_range(0, nd - 1));
      if (pick < 28) c.op = OP_LOAD;
      else if (pick < 55) c.op = OP_FITNESS;
      else c.op = OP_MOVE;
    end
    c.start_position = ($urandom_range(0, 3) == 0) ? $urandom() :
                       int'($urandom_range(0, 2097151)) - 1048576;
    c.start_velocity = ($urandom_range(0, 3) == 0) ? $urandom() :
                       int'($urandom_range(0, 131071)) - 65536;
    c.fitness = draw_fitness(c.particle);
    c.rand_cognitive = FRAC_W'($urandom_range(0, 65535));
    c.rand_social = FRAC_W'($urandom_range(0, 65535));
    return legalise(c);
  endfunction

  function automatic swarm_cmd_t cmd_of(input logic [OP_W-1:0] code, input int p, input int d,
                                        input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    swarm_cmd_t c;
    c.op = code;
    c.particle = PARTICLE_W'(p);
    c.dim = DIMF_W'(d);
    c.start_position = a;
    c.start_velocity = b;
    c.fitness = a;
    c.rand_cognitive = a[FRAC_W-1:0];
    c.rand_social = b[FRAC_W-1:0];
    return c;
  endfunction

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // Present one command and hold it until the engine takes it; start is left
  // high so a back-to-back command needs no extra edge
  task automatic issue_cmd(input swarm_cmd_t c);
    int gap;
    swarm_result_t r;
    gap = draw_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= c.op;
    particle <= c.particle;
    dim <= c.dim;
    start_position <= c.start_position;
    start_velocity <= c.start_velocity;
    fitness <= c.fitness;
    rand_cognitive <= c.rand_cognitive;
    rand_social <= c.rand_social;
    do @(posedge clk); while (busy);
    r = apply_swarm_op(c);
    predicted_outcomes.push_back(r);
    n_items++;
    if (c.op == OP_MOVE) n_moves++;
    if (c.op == OP_FITNESS) n_reports++;
    n_pbest += r.personal_improved;
    n_gbest += r.global_improved;
    n_errors += r.index_error;
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk);
  endtask

  // Both registers, back to back on one valid, once the engine is idle
  task automatic set_swarm_size(input logic [CFG_DATA_W-1:0] parts,
                                input logic [CFG_DATA_W-1:0] dims_word);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PARTICLES;
    cfg_data <= parts;
    do @(posedge clk); while (!cfg_ready);
    swarm_parts_reg = parts;
    cfg_index <= CFG_DIMS;
    cfg_data <= dims_word;
    do @(posedge clk); while (!cfg_ready);
    swarm_dims_reg = dims_word[DCOUNT_W-1:0];
    cfg_valid <= 1'b0;
    n_reg_writes += 2;
  endtask

  task automatic test_load_and_report();
    issue_cmd(cmd_of(OP_LOAD, 0, 0, FIT_MAX, WORD_MIN));
    issue_cmd(cmd_of(OP_LOAD, 0, 1, WORD_MIN, FIT_MAX));
    issue_cmd(cmd_of(OP_FITNESS, 0, 1, 32'd0, 32'd0));
    // equal fitness is no improvement
    issue_cmd(cmd_of(OP_FITNESS, 0, 0, 32'd0, 32'd0));
    issue_cmd(cmd_of(OP_LOAD, 63, 0, 32'd0, 32'd0));
    issue_cmd(cmd_of(OP_LOAD, 63, 1, 32'h0001_0000, 32'hFFFF_0000));
    issue_cmd(cmd_of(OP_FITNESS, 63, 7, FIT_MAX, 32'd0));
    // personal best only, global already lower; dim past the count reads zero
    issue_cmd(cmd_of(OP_FITNESS, 63, 2, 32'd100, 32'd0));
  endtask

  task automatic test_move_extremes();
    issue_cmd(cmd_of(OP_MOVE, 0, 0, 32'hFFFF, 32'hFFFF));
    issue_cmd(cmd_of(OP_MOVE, 63, 1, 32'h0, 32'hFFFF));
    issue_cmd(cmd_of(OP_MOVE, 63, 0, 32'h8000, 32'h1));
    // drive velocity and position into positive saturation
    issue_cmd(cmd_of(OP_MOVE, 63, 0, 32'h0, 32'hFFFF));
    issue_cmd(cmd_of(OP_MOVE, 0, 1, 32'h1, 32'h1));
  endtask

  task automatic test_index_errors();
    issue_cmd(cmd_of(OP_LOAD, 0, 2, 32'h1234_5678, 32'h9ABC_DEF0));
    issue_cmd(cmd_of(OP_MOVE, 5, 7, 32'hFFFF, 32'hFFFF));
    issue_cmd(cmd_of(OP_UNUSED, 0, 0, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
    set_swarm_size(7'd1, 7'd1);
    issue_cmd(cmd_of(OP_FITNESS, 1, 0, WORD_MIN, 32'd0));
    issue_cmd(cmd_of(OP_MOVE, 0, 0, 32'h1234, 32'h5678));
    issue_cmd(cmd_of(OP_FITNESS, 0, 1, FIT_MAX, 32'd0));
    // zero counts make every index an error
    set_swarm_size(7'd0, 7'd0);
    issue_cmd(cmd_of(OP_LOAD, 0, 0, 32'd5, 32'd5));
    issue_cmd(cmd_of(OP_FITNESS, 0, 0, WORD_MIN, 32'd0));
    // counts above the storage limits are capped
    set_swarm_size(7'd127, 7'h7F);
    issue_cmd(cmd_of(OP_LOAD, 63, 7, 32'hFFFF_FFFF, 32'h0000_0001));
  endtask

  task automatic test_random_swarm();
    logic [CFG_DATA_W-1:0] part_plan [7] = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd48, 7'd64};
    logic [CFG_DATA_W-1:0] dim_plan  [7] = '{7'd2, 7'd1, 7'h7F, 7'd3, 7'd0, 7'h76, 7'd8};
    int                    item_plan [7] = '{300, 150, 400, 250, 40, 300, 200};
    int ph;
    for (ph = 0; ph < 7; ph++) begin
      set_swarm_size(part_plan[ph], dim_plan[ph]);
      repeat (item_plan[ph]) issue_cmd(draw_swarm_cmd());
    end
  endtask

  task automatic test_fitness_floor();
    // lowest fitness: nothing can beat it afterwards
    set_swarm_size(7'd1, 7'd1);
    issue_cmd(cmd_of(OP_FITNESS, 0, 0, WORD_MIN, 32'd0));
    issue_cmd(cmd_of(OP_FITNESS, 0, 0, WORD_MIN, 32'd0));
    issue_cmd(cmd_of(OP_MOVE, 0, 0, 32'hFFFF, 32'hFFFF));
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("time %0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_outcomes.size() == 0) begin
        $display("time %0t: result beat with nothing outstanding, actual position %h",
                 $time, new_position);
        mismatches++;
      end else begin
        due = predicted_outcomes.pop_front();
        check_field("new_position", due.new_position, new_position);
        check_field("new_velocity", due.new_velocity, new_velocity);
        check_field("personal_improved", WORD_W'(due.personal_improved),
                    WORD_W'(personal_improved));
        check_field("global_improved", WORD_W'(due.global_improved),
                    WORD_W'(global_improved));
        check_field("global_best_fitness", due.global_best_fitness, global_best_fitness);
        check_field("index_error", WORD_W'(due.index_error), WORD_W'(index_error));
      end
    end
  end

  // Slowest beat is the longest random gap plus a full eight-word best copy
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) begin
      pos_loaded[i] = 1'b0;
      pbest_valid[i] = 1'b0;
    end
    for (int i = 0; i < MAX_PARTICLES; i++) sw_pbest_fit[i] = FIT_MAX;
    for (int i = 0; i < MAX_DIMS; i++) sw_gbest[i] = '0;
    sw_gbest_fit = FIT_MAX;
    swarm_parts_reg = PARTS_RESET;
    swarm_dims_reg = DIMS_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_load_and_report();
    test_move_extremes();
    test_index_errors();
    test_random_swarm();
    test_fitness_floor();
    wait_results();
    repeat (30) @(posedge clk);
    $display("Covered %0d commands: %0d moves, %0d fitness reports, %0d index errors",
             n_items, n_moves, n_reports, n_errors);
    $display("Best updates: %0d personal, %0d global; %0d register writes",
             n_pbest, n_gbest, n_reg_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== particle_swarm_update_engine.f =====
src/pso_pkg.sv
src/pso_ctrl.sv
src/pso_dp.sv
src/particle_swarm_update_engine.sv
src/pso_checker.sv
test/tb_top.sv
